// File: rtl/acodon_pkg.sv
// ----------------------------------------------------------------------------
// acodon_pkg: shared definitions for the ambiguous codon translation table
// Request codes, field widths, symbol constants and nucleotide code helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package acodon_pkg;

  localparam int unsigned CODE_W   = 4;
  localparam int unsigned SYM_W    = 8;
  localparam int unsigned REQ_W    = 2;
  localparam int unsigned TBL_DEPTH = 64;
  localparam int unsigned TBL_AW   = 6;

  typedef logic [REQ_W-1:0]  req_t;
  typedef logic [CODE_W-1:0] code_t;
  typedef logic [SYM_W-1:0]  sym_t;
  typedef logic [TBL_AW-1:0] tbl_addr_t;

  localparam req_t REQ_CLEAR  = 2'd0;
  localparam req_t REQ_WRITE  = 2'd1;
  localparam req_t REQ_LOOKUP = 2'd2;

  localparam code_t CODE_ANY = 4'd0;
  localparam code_t CODE_GAP = 4'd15;

  localparam sym_t SYM_UNKNOWN = 8'h58;  // 'X'
  localparam sym_t SYM_LC_A    = 8'h61;  // 'a'
  localparam sym_t SYM_LC_Z    = 8'h7A;  // 'z'
  localparam sym_t SYM_CASE    = 8'h20;

  // Plain bases a code stands for (bit b = base b); empty for a gap.
  function automatic code_t base_set(input code_t code);
    code_t s;
    s = code;
    if (code == CODE_GAP) begin
      s = '0;
    end else if (code == CODE_ANY) begin
      s = CODE_GAP;
    end
    return s;
  endfunction

  function automatic sym_t to_upper(input sym_t v);
    sym_t u;
    u = v;
    if (v >= SYM_LC_A && v <= SYM_LC_Z) begin
      u = v - SYM_CASE;
    end
    return u;
  endfunction

endpackage

`default_nettype wire

// File: rtl/acodon_ram.sv
// ----------------------------------------------------------------------------
// acodon_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module acodon_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/ambiguous_codon_translation_table.sv
// ----------------------------------------------------------------------------
// ambiguous_codon_translation_table: codon to amino acid lookup table
// Stores one symbol per plain codon and resolves ambiguous codons on lookup.
// ----------------------------------------------------------------------------
// A clear and an ignored request code are done on acceptance. A write and
// a lookup without a gap sweep all 64 plain codons through one table port,
// one codon per cycle; a write holds the input for its sweep, a lookup for
// its sweep, a drain state and a finish state that loads the answer into
// the output register. The sweep counter addresses the RAM write port for a
// write and the read port for a lookup. A lookup with a gap in any position
// goes straight to the finish state and answers 'X' without touching the
// table. Input is not taken while a request is being worked on; a finished
// result waits in the output register while the next request is accepted,
// and a lookup that finishes while the output register is still full holds
// until the sink takes the older answer. There is no clearing pass: a valid
// bit per entry makes reset and clear take effect at once.
// ----------------------------------------------------------------------------
`default_nettype none

module ambiguous_codon_translation_table
  import acodon_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [3:0] first_code, [7:4] second_code, [11:8] third_code, [19:12] symbol_in,
  // [23:20] zero
  input  wire logic [23:0] in_tdata,
  // [1:0] req_type
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [7:0] symbol_out
  output logic [7:0]       out_tdata
);

  // Sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_WRITE = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  logic [2:0]     state_r, state_nxt;
  tbl_addr_t      cnt_r, cnt_nxt;
  code_t          s1_r, s2_r, s3_r;
  sym_t           sym_r;
  logic [TBL_DEPTH-1:0] valid_r;

  // Lookup compare stage
  logic           pend_r;
  logic           vld_d_r;
  logic           seen_r;
  logic           mismatch_r;
  sym_t           common_r;
  sym_t           res_sym;
  logic           gap_r;

  logic           out_tvalid_r;
  sym_t           out_tdata_r;

  logic           in_fire;
  req_t           req;
  code_t          in_s1, in_s2, in_s3;
  logic           member;
  logic           last;
  logic           ram_we, ram_re;
  sym_t           ram_rdata;
  sym_t           entry;
  logic           out_free;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign req        = in_tuser;
  assign in_s1      = base_set(in_tdata[3:0]);
  assign in_s2      = base_set(in_tdata[7:4]);
  assign in_s3      = base_set(in_tdata[11:8]);

  // Is the plain codon under the counter one of the expansions?
  assign member = s1_r[cnt_r[5:4]] && s2_r[cnt_r[3:2]] && s3_r[cnt_r[1:0]];
  assign last   = &cnt_r;

  assign ram_we = (state_r == ST_WRITE) && member;
  assign ram_re = (state_r == ST_READ) && member;

  // Entries never written since reset or clear read as 'X'.
  assign entry    = vld_d_r ? ram_rdata : SYM_UNKNOWN;
  assign out_free = !out_tvalid_r || out_tready;

  acodon_ram #(
    .WIDTH (SYM_W),
    .DEPTH (TBL_DEPTH),
    .AW    (TBL_AW)
  ) u_table (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (cnt_r),
    .wdata   (sym_r),
    .re      (ram_re),
    .raddr   (cnt_r),
    .rdata_r (ram_rdata)
  );

  // Next state and sweep counter
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (in_fire) begin
          priority if (req == REQ_WRITE) begin
            state_nxt = ST_WRITE;
          end else if (req == REQ_LOOKUP) begin
            // A gap answers at once; otherwise sweep the table.
            if (in_s1 == '0 || in_s2 == '0 || in_s3 == '0) begin
              state_nxt = ST_FIN;
            end else begin
              state_nxt = ST_READ;
            end
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_WRITE: begin
        cnt_nxt = cnt_r + 1'b1;
        if (last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_READ: begin
        cnt_nxt = cnt_r + 1'b1;
        if (last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      valid_r      <= '0;
      pend_r       <= 1'b0;
      seen_r       <= 1'b0;
      mismatch_r   <= 1'b0;
      gap_r        <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= ram_re;

      if (in_fire && req == REQ_CLEAR) begin
        valid_r <= '0;
      end else if (ram_we) begin
        valid_r[cnt_r] <= 1'b1;
      end

      // Start each lookup with nothing seen.
      if (in_fire) begin
        seen_r     <= 1'b0;
        mismatch_r <= 1'b0;
        gap_r      <= (in_s1 == '0 || in_s2 == '0 || in_s3 == '0);
      end else if (pend_r) begin
        seen_r <= 1'b1;
        if (seen_r && entry != common_r) begin
          mismatch_r <= 1'b1;
        end
      end

      // Hold the result until the sink takes it.
      if (state_r == ST_FIN && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r  <= in_s1;
      s2_r  <= in_s2;
      s3_r  <= in_s3;
      sym_r <= to_upper(in_tdata[19:12]);
    end
    vld_d_r <= valid_r[cnt_r];
    if (pend_r && !seen_r) begin
      common_r <= entry;
    end
    if (state_r == ST_FIN && out_free) begin
      out_tdata_r <= res_sym;
    end
  end

  always_comb begin
    res_sym = common_r;
    if (gap_r || mismatch_r) begin
      res_sym = SYM_UNKNOWN;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

`ifndef ASSERT_OFF
  // A clear has emptied the whole table by the next cycle.
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && req == REQ_CLEAR) |=> (valid_r == '0))
    else $error("table not emptied after clear");

  // Read data is only compared in the cycle after a sweep read.
  a_pend_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> ($past(state_r) == ST_READ))
    else $error("compare without a preceding table read");

  // A lookup without a gap always sees at least one expansion.
  a_drain_seen: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |=> (seen_r && !gap_r))
    else $error("lookup finished without any expansion");

  // A lookup with a gap skips the table sweep.
  a_gap_skips: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && req == REQ_LOOKUP &&
     (in_s1 == '0 || in_s2 == '0 || in_s3 == '0)) |=> (state_r == ST_FIN))
    else $error("gap lookup entered the sweep");
`endif

endmodule

`default_nettype wire

// File: sim/tb_ambiguous_codon_translation_table.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ambiguous_codon_translation_table: self-checking bench for the codon table
// Streams clear, write, lookup and unused requests into the block, mirrors the
// table in a shadow copy and checks every lookup answer against it, in order.
// ----------------------------------------------------------------------------

module tb_ambiguous_codon_translation_table
  import acodon_pkg::*;
();

  // Request code the block must ignore without touching the table
  localparam req_t REQ_IGNORED = 2'd3;

  localparam int unsigned RESET_CYCLES = 10;
  localparam int unsigned IDLE_PCT     = 11;
  localparam int unsigned RANDOM_ITEMS = 650;
  // Leave a good margin after the last answer
  localparam int unsigned DRAIN_CYCLES = 150;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned REPORT_MAX   = 10;

  typedef struct packed {
    req_t  req;
    code_t c1;
    code_t c2;
    code_t c3;
    sym_t  sym;
  } codon_req_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  // [3:0] first_code, [7:4] second_code, [11:8] third_code, [19:12] symbol_in,
  // [23:20] zero
  logic [23:0] in_tdata = '0;
  // [1:0] req_type
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // [7:0] symbol_out
  logic [7:0]  out_tdata;

  ambiguous_codon_translation_table DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Requests waiting to be driven, and lookup answers still owed by the block
  codon_req_t pending_reqs[$];
  sym_t       expected_symbols[$];

  // Shadow of the 64-entry table, index 16*b1 + 4*b2 + b3 (C=0 T=1 A=2 G=3)
  sym_t shadow_table [TBL_DEPTH];

  int unsigned accepted_cnt = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;
  logic        quiet;

  // Hold both sides busy without gaps over a long stretch of the run
  assign quiet = (accepted_cnt >= 300) && (accepted_cnt < 420);

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < TBL_DEPTH; i++) begin
      shadow_table[i] = SYM_UNKNOWN;
    end
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
  end

  // --------------------------------------------------------------------------
  // Shadow table predictor
  // --------------------------------------------------------------------------

  // Plain bases a nucleotide code covers: N covers all four, a gap none
  function automatic logic [3:0] bases_of(input code_t code);
    if (code == CODE_GAP) begin
      return 4'h0;
    end
    if (code == CODE_ANY) begin
      return 4'hF;
    end
    return code;
  endfunction

  // Only lower-case ASCII letters change on a store
  function automatic sym_t fold_case(input sym_t v);
    if (v >= 8'h61 && v <= 8'h7A) begin
      return v - 8'h20;
    end
    return v;
  endfunction

  // Advance the shadow table by one accepted transaction; queue the answer
  // of a lookup
  task automatic translate_request(input codon_req_t rq);
    logic [3:0] s1, s2, s3;
    sym_t       common;
    sym_t       entry;
    bit         seen;
    bit         agree;
    s1 = bases_of(rq.c1);
    s2 = bases_of(rq.c2);
    s3 = bases_of(rq.c3);
    seen = 1'b0;
    agree = 1'b1;
    common = SYM_UNKNOWN;
    case (rq.req)
      REQ_CLEAR: begin
        for (int i = 0; i < TBL_DEPTH; i++) begin
          shadow_table[i] = SYM_UNKNOWN;
        end
      end
      REQ_WRITE: begin
        // A gap in any position expands to nothing, so nothing is stored
        for (int a = 0; a < 4; a++) begin
          for (int b = 0; b < 4; b++) begin
            for (int c = 0; c < 4; c++) begin
              if (s1[a] && s2[b] && s3[c]) begin
                shadow_table[a * 16 + b * 4 + c] = fold_case(rq.sym);
              end
            end
          end
        end
      end
      REQ_LOOKUP: begin
        if (s1 == 4'h0 || s2 == 4'h0 || s3 == 4'h0) begin
          expected_symbols.push_back(SYM_UNKNOWN);
        end else begin
          for (int a = 0; a < 4; a++) begin
            for (int b = 0; b < 4; b++) begin
              for (int c = 0; c < 4; c++) begin
                if (s1[a] && s2[b] && s3[c]) begin
                  entry = shadow_table[a * 16 + b * 4 + c];
                  if (!seen) begin
                    common = entry;
                    seen = 1'b1;
                  end else if (entry != common) begin
                    agree = 1'b0;
                  end
                end
              end
            end
          end
          expected_symbols.push_back(agree ? common : SYM_UNKNOWN);
        end
      end
      default: begin
        // Unused request code: no state change, no answer
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  task automatic add_req(input req_t req, input code_t c1, input code_t c2,
                         input code_t c3, input sym_t sym);
    codon_req_t rq;
    rq.req = req;
    rq.c1 = c1;
    rq.c2 = c2;
    rq.c3 = c3;
    rq.sym = sym;
    pending_reqs.push_back(rq);
  endtask

  // Mostly plain bases, with ambiguous codes, N, gaps and anything else mixed in
  function automatic code_t rand_code();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) begin
      return code_t'(4'h1 << $urandom_range(3));
    end
    if (r < 75) begin
      return code_t'($urandom_range(14, 1));
    end
    if (r < 85) begin
      return CODE_ANY;
    end
    if (r < 90) begin
      return CODE_GAP;
    end
    return code_t'($urandom_range(15));
  endfunction

  // Amino acid letters in either case, now and then any byte at all
  function automatic sym_t rand_symbol();
    string letters;
    sym_t  s;
    letters = "ACDEFGHIKLMNPQRSTVWY*";
    if ($urandom_range(99) < 20) begin
      return sym_t'($urandom_range(255));
    end
    s = letters[$urandom_range(letters.len() - 1)];
    if (s != 8'h2A && $urandom_range(1) == 1) begin
      s = s | 8'h20;
    end
    return s;
  endfunction

  // A code covering a non-empty subset of the bases of another code, so that
  // a lookup lands inside a region that one write filled
  function automatic code_t sub_code(input code_t code);
    logic [3:0] bases;
    logic [3:0] pick;
    bases = bases_of(code);
    if (bases == 4'h0) begin
      return CODE_GAP;
    end
    do begin
      pick = 4'($urandom_range(15, 1)) & bases;
    end while (pick == 4'h0);
    // All four bases must be spelled N: the all-ones code is a gap
    if (pick == 4'hF) begin
      return CODE_ANY;
    end
    return pick;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus: directed cases, then a random mix; then drain and report
  // --------------------------------------------------------------------------
  initial begin
    codon_req_t last_write;
    int unsigned r;

    // Lookup on the table fresh out of reset
    add_req(REQ_LOOKUP, CODE_ANY, CODE_ANY, CODE_ANY, 8'h00);
    // Plain write with a lower-case symbol, then read it back
    add_req(REQ_WRITE, 4'h1, 4'h2, 4'h4, 8'h6D);
    add_req(REQ_LOOKUP, 4'h1, 4'h2, 4'h4, 8'h00);
    // Ambiguous write over GGN, lookups on a subset and on the full set
    add_req(REQ_WRITE, 4'h8, 4'h8, CODE_ANY, 8'h67);
    add_req(REQ_LOOKUP, 4'h8, 4'h8, 4'h3, 8'h00);
    add_req(REQ_LOOKUP, 4'h8, 4'h8, CODE_ANY, 8'h00);
    // Write with a gap stores nothing
    add_req(REQ_WRITE, CODE_GAP, 4'h1, 4'h1, 8'h5A);
    // Lookups with a gap in each position
    add_req(REQ_LOOKUP, CODE_GAP, CODE_GAP, CODE_GAP, 8'hFF);
    add_req(REQ_LOOKUP, 4'h1, CODE_GAP, 4'h1, 8'h00);
    add_req(REQ_LOOKUP, 4'h1, 4'h1, CODE_GAP, 8'h00);
    // Unused request code with every field at its maximum
    add_req(REQ_IGNORED, CODE_GAP, CODE_GAP, CODE_GAP, 8'hFF);
    // Fill the whole table with the lowest symbol and read it all at once
    add_req(REQ_WRITE, CODE_ANY, CODE_ANY, CODE_ANY, 8'h00);
    add_req(REQ_LOOKUP, CODE_ANY, CODE_ANY, CODE_ANY, 8'h00);
    // Highest symbol on one codon: the full lookup now disagrees
    add_req(REQ_WRITE, 4'h4, 4'h4, 4'h4, 8'hFF);
    add_req(REQ_LOOKUP, CODE_ANY, CODE_ANY, CODE_ANY, 8'h00);
    add_req(REQ_LOOKUP, 4'h4, 4'h4, 4'h4, 8'h00);
    // Case folding at the edges of the lower-case range and just outside it
    add_req(REQ_WRITE, 4'h2, 4'h2, 4'h2, 8'h61);
    add_req(REQ_WRITE, 4'h2, 4'h2, 4'h1, 8'h7A);
    add_req(REQ_WRITE, 4'h1, 4'h1, 4'h1, 8'h60);
    add_req(REQ_WRITE, 4'h1, 4'h1, 4'h2, 8'h7B);
    add_req(REQ_LOOKUP, 4'h2, 4'h2, 4'h2, 8'h00);
    add_req(REQ_LOOKUP, 4'h2, 4'h2, 4'h1, 8'h00);
    add_req(REQ_LOOKUP, 4'h1, 4'h1, 4'h3, 8'h00);
    // Clear, then confirm the table is back to unknown
    add_req(REQ_CLEAR, CODE_GAP, 4'h5, 4'hA, 8'hA5);
    add_req(REQ_LOOKUP, 4'h2, 4'h2, 4'h2, 8'h00);

    last_write = '0;
    last_write.c1 = CODE_ANY;
    last_write.c2 = CODE_ANY;
    last_write.c3 = CODE_ANY;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      r = $urandom_range(99);
      if (r < 3) begin
        add_req(REQ_CLEAR, code_t'($urandom_range(15)), code_t'($urandom_range(15)),
                code_t'($urandom_range(15)), sym_t'($urandom_range(255)));
      end else if (r < 6) begin
        add_req(REQ_IGNORED, code_t'($urandom_range(15)), code_t'($urandom_range(15)),
                code_t'($urandom_range(15)), sym_t'($urandom_range(255)));
      end else if (r < 50) begin
        last_write.req = REQ_WRITE;
        last_write.c1 = rand_code();
        last_write.c2 = rand_code();
        last_write.c3 = rand_code();
        last_write.sym = rand_symbol();
        pending_reqs.push_back(last_write);
      end else if (r < 75) begin
        add_req(REQ_LOOKUP, sub_code(last_write.c1), sub_code(last_write.c2),
                sub_code(last_write.c3), sym_t'($urandom_range(255)));
      end else begin
        add_req(REQ_LOOKUP, rand_code(), rand_code(), rand_code(),
                sym_t'($urandom_range(255)));
      end
    end

    // Wait on the falling edge so the clocked blocks have settled
    do @(negedge clk); while (pending_reqs.size() != 0 || in_tvalid);
    do @(negedge clk); while (expected_symbols.size() != 0);
    // Any stray answer after this point is caught by the monitor
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_cnt == 0 && expected_symbols.size() == 0) begin
      $display("tb_ambiguous_codon_translation_table passed");
    end else begin
      $display("tb_ambiguous_codon_translation_table failed");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driver: present one request at a time, predict on each transaction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive_requests
    codon_req_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= '0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) begin
        // Transaction completed at this edge: decode what was on the bus
        nxt.req = in_tuser;
        nxt.c1  = in_tdata[3:0];
        nxt.c2  = in_tdata[7:4];
        nxt.c3  = in_tdata[11:8];
        nxt.sym = in_tdata[19:12];
        translate_request(nxt);
        accepted_cnt <= accepted_cnt + 1;
      end
      if (pending_reqs.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
        nxt = pending_reqs.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {4'h0, nxt.sym, nxt.c3, nxt.c2, nxt.c1};
        in_tuser  <= nxt.req;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: stall the result side at random and check each answer in order
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_answers
    sym_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_symbols.size() == 0) begin
          if (mismatch_cnt < REPORT_MAX) begin
            $display("ERROR: unexpected answer 0x%02h with no lookup pending", out_tdata);
          end
          mismatch_cnt <= mismatch_cnt + 1;
        end else begin
          want = expected_symbols.pop_front();
          if (out_tdata !== want) begin
            if (mismatch_cnt < REPORT_MAX) begin
              $display("ERROR: symbol_out expected 0x%02h, got 0x%02h", want, out_tdata);
            end
            mismatch_cnt <= mismatch_cnt + 1;
          end
        end
      end
      out_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Drop the run if the block hangs
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb_ambiguous_codon_translation_table failed");
      $finish;
    end
  end

endmodule
